// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmq check failed");

// consequent in the cycle after the antecedent
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmq check failed");

`endif

// File: hw/rtl/rmq_pkg.sv
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int M_W       = 16;
	localparam int T_W       = 32;
	localparam int Q_W       = 16;

	// numerators are sums or differences of two entries
	localparam int N_W       = M_W + 1;
	// magnitude of the most negative numerator needs all N_W bits
	localparam int MAG_W     = N_W;
	// 1 + three entries: always below 2^17 for a positive result
	localparam int RAD_W     = M_W + 1;
	localparam int RADX_W    = M_W + 4;

	localparam int V_RAW     = RAD_W + FRAC_BITS + 2;
	localparam int V_W       = V_RAW + (V_RAW % 2);
	localparam int ROOT_W    = V_W / 2;
	localparam int REM_W     = ROOT_W + 3;

	localparam int QB        = Q_W;
	localparam int DEN_W     = ROOT_W + 1;
	localparam int DW        = DEN_W + QB + 1;

	localparam int LAT       = ROOT_W + QB + 3;

	typedef enum logic [1:0] {
		BR_W,
		BR_X,
		BR_Y,
		BR_Z
	} br_t;

	typedef struct packed {
		logic signed [T_W-1:0] x;
		logic signed [T_W-1:0] y;
		logic signed [T_W-1:0] z;
	} trans_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] q;
		logic          ovf;
		logic          neg;
	} lane_t;

endpackage

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion, one rigid transform per item.
// Input: nine rotation entries m00..m22 in signed Q2.14 and a translation
// trans_in_x/y/z in signed Q16.16, taken at a clock edge with start high
// and busy low. busy is always low: an item can enter in every cycle.
// Output: quat_w/x/y/z in signed Q2.14 (saturated) and trans_out_x/y/z,
// shown for one cycle with done high. The receiver cannot stall the block.
// Throughput is one item per clock.
// The pipeline is a front stage (branch pick, radicand, numerators),
// 17 stages of a one-bit-per-stage square root, a divide setup stage,
// 16 stages of three parallel one-bit-per-stage dividers by the root,
// and an output stage that saturates and routes the components.
// Reset clears the valid bits only; items in flight are dropped and no
// done strobe follows until a new item is taken.
module rotation_matrix_to_quaternion (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [rmq_pkg::M_W-1:0] m00,
	input  logic signed [rmq_pkg::M_W-1:0] m10,
	input  logic signed [rmq_pkg::M_W-1:0] m20,
	input  logic signed [rmq_pkg::M_W-1:0] m01,
	input  logic signed [rmq_pkg::M_W-1:0] m11,
	input  logic signed [rmq_pkg::M_W-1:0] m21,
	input  logic signed [rmq_pkg::M_W-1:0] m02,
	input  logic signed [rmq_pkg::M_W-1:0] m12,
	input  logic signed [rmq_pkg::M_W-1:0] m22,
	input  logic signed [rmq_pkg::T_W-1:0] trans_in_x,
	input  logic signed [rmq_pkg::T_W-1:0] trans_in_y,
	input  logic signed [rmq_pkg::T_W-1:0] trans_in_z,
	output logic                        done,
	output logic signed [rmq_pkg::Q_W-1:0] quat_w,
	output logic signed [rmq_pkg::Q_W-1:0] quat_x,
	output logic signed [rmq_pkg::Q_W-1:0] quat_y,
	output logic signed [rmq_pkg::Q_W-1:0] quat_z,
	output logic signed [rmq_pkg::T_W-1:0] trans_out_x,
	output logic signed [rmq_pkg::T_W-1:0] trans_out_y,
	output logic signed [rmq_pkg::T_W-1:0] trans_out_z
);
	import rmq_pkg::*;

`include "assert_macros.svh"

	typedef struct packed {
		br_t                   sel;
		logic signed [N_W-1:0] n0;
		logic signed [N_W-1:0] n1;
		logic signed [N_W-1:0] n2;
		trans_t                t;
		logic [RAD_W-1:0]      rad;
	} fe_t;

	typedef struct packed {
		br_t                   sel;
		logic signed [N_W-1:0] n0;
		logic signed [N_W-1:0] n1;
		logic signed [N_W-1:0] n2;
		trans_t                t;
		logic [REM_W-1:0]      rem;
		logic [ROOT_W-1:0]     root;
		logic [V_W-1:0]        v;
	} sq_t;

	typedef struct packed {
		br_t               sel;
		trans_t            t;
		logic [ROOT_W-1:0] u;
		lane_t             l0;
		lane_t             l1;
		lane_t             l2;
	} dv_t;

	function automatic logic signed [RADX_W-1:0] sx(input logic signed [M_W-1:0] a);
		return RADX_W'(a);
	endfunction

	function automatic logic signed [N_W-1:0] nx(input logic signed [M_W-1:0] a);
		return N_W'(a);
	endfunction

	function automatic lane_t div_setup(input logic signed [N_W-1:0] n,
		input logic [ROOT_W-1:0] u);
		lane_t          l;
		logic [N_W-1:0] mag;
		logic [DW-1:0]  dd;
		logic [DW-1:0]  lim;
		mag   = n[N_W-1] ? N_W'(-n) : N_W'(n);
		dd    = (DW'(mag[MAG_W-1:0]) << (FRAC_BITS + 1)) + DW'(u);
		lim   = DW'({u, 1'b0}) << QB;
		l.rem = dd;
		l.q   = '0;
		l.ovf = (dd >= lim);
		l.neg = n[N_W-1];
		return l;
	endfunction

	function automatic lane_t div_step(input lane_t l, input logic [ROOT_W-1:0] u,
		input int k);
		lane_t         r;
		logic [DW-1:0] sh;
		r  = l;
		sh = DW'({u, 1'b0}) << k;
		if (l.rem >= sh) begin
			r.rem  = l.rem - sh;
			r.q[k] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [Q_W-1:0] div_out(input lane_t l,
		input logic [ROOT_W-1:0] u);
		logic signed [Q_W-1:0] r;
		if (u == '0) begin
			r = '0;
		end else if (l.neg) begin
			if (l.ovf || (l.q > QB'(1 << (Q_W - 1))))
				r = Q_W'(-(1 << (Q_W - 1)));
			else
				r = Q_W'(-$signed({1'b0, l.q}));
		end else begin
			if (l.ovf || (l.q > QB'((1 << (Q_W - 1)) - 1)))
				r = Q_W'((1 << (Q_W - 1)) - 1);
			else
				r = $signed(l.q);
		end
		return r;
	endfunction

	// front stage
	logic signed [RADX_W-1:0] tr, rad_x;
	logic                     x_lead, y_lead;
	fe_t                      fe_d;
	fe_t                      fe_s1;
	logic                     v_s1;

	always_comb begin
		tr     = sx(m00) + sx(m11) + sx(m22);
		x_lead = (m00 > m11) && (m00 > m22);
		y_lead = (m11 > m22);
		fe_d.t = '{x: trans_in_x, y: trans_in_y, z: trans_in_z};
		if (tr > 0) begin
			fe_d.sel = BR_W;
			rad_x    = RADX_W'(1 << FRAC_BITS) + tr;
			fe_d.n0  = nx(m21) - nx(m12);
			fe_d.n1  = nx(m02) - nx(m20);
			fe_d.n2  = nx(m10) - nx(m01);
		end else if (x_lead) begin
			fe_d.sel = BR_X;
			rad_x    = RADX_W'(1 << FRAC_BITS) + sx(m00) - sx(m11) - sx(m22);
			fe_d.n0  = nx(m21) - nx(m12);
			fe_d.n1  = nx(m01) + nx(m10);
			fe_d.n2  = nx(m02) + nx(m20);
		end else if (y_lead) begin
			fe_d.sel = BR_Y;
			rad_x    = RADX_W'(1 << FRAC_BITS) + sx(m11) - sx(m00) - sx(m22);
			fe_d.n0  = nx(m02) - nx(m20);
			fe_d.n1  = nx(m01) + nx(m10);
			fe_d.n2  = nx(m12) + nx(m21);
		end else begin
			fe_d.sel = BR_Z;
			rad_x    = RADX_W'(1 << FRAC_BITS) + sx(m22) - sx(m00) - sx(m11);
			fe_d.n0  = nx(m10) - nx(m01);
			fe_d.n1  = nx(m02) + nx(m20);
			fe_d.n2  = nx(m12) + nx(m21);
		end
		// negative radicand clamps to zero
		fe_d.rad = rad_x[RADX_W-1] ? '0 : rad_x[RAD_W-1:0];
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		if (start)
			fe_s1 <= fe_d;
	end

	// square root, one result bit per stage
	sq_t  sq_s [ROOT_W];
	logic sqv_s [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		sq_t              cur, nxt;
		logic [REM_W-1:0] rem2, trial;
		logic             vin;

		always_comb begin
			if (j == 0) begin
				cur.sel  = fe_s1.sel;
				cur.n0   = fe_s1.n0;
				cur.n1   = fe_s1.n1;
				cur.n2   = fe_s1.n2;
				cur.t    = fe_s1.t;
				cur.rem  = '0;
				cur.root = '0;
				cur.v    = V_W'(fe_s1.rad) << (FRAC_BITS + 2);
				vin      = v_s1;
			end else begin
				cur = sq_s[(j == 0) ? 0 : j - 1];
				vin = sqv_s[(j == 0) ? 0 : j - 1];
			end
			nxt   = cur;
			rem2  = {cur.rem[REM_W-3:0], cur.v[V_W-1 -: 2]};
			trial = REM_W'({cur.root, 2'b01});
			nxt.v = cur.v << 2;
			if (rem2 >= trial) begin
				nxt.rem  = rem2 - trial;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rem2;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[j] <= 1'b0;
			else
				sqv_s[j] <= vin;
		end

		always_ff @(posedge clk) begin
			if (vin)
				sq_s[j] <= nxt;
		end
	end

	// divide setup
	dv_t  dv_s2;
	logic dvv_s2;
	dv_t  dv_d;

	always_comb begin
		dv_d.sel = sq_s[ROOT_W-1].sel;
		dv_d.t   = sq_s[ROOT_W-1].t;
		dv_d.u   = sq_s[ROOT_W-1].root;
		dv_d.l0  = div_setup(sq_s[ROOT_W-1].n0, sq_s[ROOT_W-1].root);
		dv_d.l1  = div_setup(sq_s[ROOT_W-1].n1, sq_s[ROOT_W-1].root);
		dv_d.l2  = div_setup(sq_s[ROOT_W-1].n2, sq_s[ROOT_W-1].root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dvv_s2 <= 1'b0;
		else
			dvv_s2 <= sqv_s[ROOT_W-1];
	end

	always_ff @(posedge clk) begin
		if (sqv_s[ROOT_W-1])
			dv_s2 <= dv_d;
	end

	// three dividers, one quotient bit per stage, msb first
	dv_t  dq_s [QB];
	logic dqv_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		dv_t  cur, nxt;
		logic vin;

		always_comb begin
			if (j == 0) begin
				cur = dv_s2;
				vin = dvv_s2;
			end else begin
				cur = dq_s[(j == 0) ? 0 : j - 1];
				vin = dqv_s[(j == 0) ? 0 : j - 1];
			end
			nxt    = cur;
			nxt.l0 = div_step(cur.l0, cur.u, QB - 1 - j);
			nxt.l1 = div_step(cur.l1, cur.u, QB - 1 - j);
			nxt.l2 = div_step(cur.l2, cur.u, QB - 1 - j);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dqv_s[j] <= 1'b0;
			else
				dqv_s[j] <= vin;
		end

		always_ff @(posedge clk) begin
			if (vin)
				dq_s[j] <= nxt;
		end
	end

	// saturate and route
	dv_t                   last;
	logic signed [Q_W-1:0] c0, c1, c2, lead;
	logic signed [Q_W-1:0] qw_d, qx_d, qy_d, qz_d;
	logic [ROOT_W-1:0]     ur;
	br_t                   sel_s3;

	always_comb begin
		last = dq_s[QB-1];
		c0   = div_out(last.l0, last.u);
		c1   = div_out(last.l1, last.u);
		c2   = div_out(last.l2, last.u);
		ur   = (last.u + ROOT_W'(2)) >> 2;
		lead = Q_W'(ur);
		case (last.sel)
			BR_W: begin
				qw_d = lead; qx_d = c0; qy_d = c1; qz_d = c2;
			end
			BR_X: begin
				qw_d = c0; qx_d = lead; qy_d = c1; qz_d = c2;
			end
			BR_Y: begin
				qw_d = c0; qx_d = c1; qy_d = lead; qz_d = c2;
			end
			default: begin
				qw_d = c0; qx_d = c1; qy_d = c2; qz_d = lead;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dqv_s[QB-1];
	end

	always_ff @(posedge clk) begin
		if (dqv_s[QB-1]) begin
			quat_w      <= qw_d;
			quat_x      <= qx_d;
			quat_y      <= qy_d;
			quat_z      <= qz_d;
			trans_out_x <= last.t.x;
			trans_out_y <= last.t.y;
			trans_out_z <= last.t.z;
			sel_s3      <= last.sel;
		end
	end

	`RMQ_ASSERT_IMPL(a_done_lat, done, $past(start, LAT))
	`RMQ_ASSERT_IMPL(a_lead_pos, done && (sel_s3 == BR_W), !quat_w[Q_W-1])
	`RMQ_ASSERT_NEXT(a_never_busy, 1'b1, !busy)

endmodule

// File: verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rmq_pkg::*;

	typedef struct packed {
		logic signed [M_W-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
		logic signed [T_W-1:0] tx, ty, tz;
	} pose_t;

	typedef struct packed {
		logic signed [Q_W-1:0] w, x, y, z;
		logic signed [T_W-1:0] tx, ty, tz;
	} quat_pose_t;

	// directed row: pose, whether the quaternion is typed in, and that quaternion
	typedef struct packed {
		pose_t p;
		logic  known;
		logic signed [Q_W-1:0] w, x, y, z;
	} row_t;

	localparam int N_RANDOM = 1730;
	localparam int WATCHDOG = 3000;
	localparam logic signed [M_W-1:0] ONE = 16'sd16384;
	localparam logic signed [M_W-1:0] MAXV = 16'sh7fff;
	localparam logic signed [M_W-1:0] MINV = 16'sh8000;

	logic clk, arst_n, start, busy, done;
	logic signed [M_W-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
	logic signed [T_W-1:0] trans_in_x, trans_in_y, trans_in_z;
	logic signed [Q_W-1:0] quat_w, quat_x, quat_y, quat_z;
	logic signed [T_W-1:0] trans_out_x, trans_out_y, trans_out_z;

	quat_pose_t pending_quats[$];
	logic       typed_known[$];
	quat_pose_t typed_quats[$];
	int errors, accepted, results, idle_cycles;
	int branch_count[4];

	rotation_matrix_to_quaternion dut (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat_q(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// n / root in fixed point, rounded half away from zero
	function automatic longint scaled_div(input longint n, input longint unsigned u);
		longint unsigned mag, q;
		if (u == 0) return 0;
		mag = (n < 0) ? longint'(-n) : longint'(n);
		mag <<= FRAC_BITS;
		q = (2 * mag + u) / (2 * u);
		return sat_q((n < 0) ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint unsigned twice_root(input longint rad);
		if (rad < 0) rad = 0;
		return int_sqrt(longint'(rad) << (FRAC_BITS + 2));
	endfunction

	function automatic br_t pick_branch(input pose_t p);
		longint tr;
		tr = p.m00 + p.m11 + p.m22;
		if (tr > 0) return BR_W;
		if (p.m00 > p.m11 && p.m00 > p.m22) return BR_X;
		if (p.m11 > p.m22) return BR_Y;
		return BR_Z;
	endfunction

	function automatic quat_pose_t quat_of_pose(input pose_t p);
		quat_pose_t q;
		longint a00, a10, a20, a01, a11, a21, a02, a12, a22, w, x, y, z, one;
		longint unsigned u;
		a00 = p.m00; a10 = p.m10; a20 = p.m20;
		a01 = p.m01; a11 = p.m11; a21 = p.m21;
		a02 = p.m02; a12 = p.m12; a22 = p.m22;
		one = longint'(1) << FRAC_BITS;
		case (pick_branch(p))
			BR_W: begin
				u = twice_root(one + a00 + a11 + a22);
				w = sat_q((u + 2) >> 2);
				x = scaled_div(a21 - a12, u);
				y = scaled_div(a02 - a20, u);
				z = scaled_div(a10 - a01, u);
			end
			BR_X: begin
				u = twice_root(one + a00 - a11 - a22);
				w = scaled_div(a21 - a12, u);
				x = sat_q((u + 2) >> 2);
				y = scaled_div(a01 + a10, u);
				z = scaled_div(a02 + a20, u);
			end
			BR_Y: begin
				u = twice_root(one + a11 - a00 - a22);
				w = scaled_div(a02 - a20, u);
				x = scaled_div(a01 + a10, u);
				y = sat_q((u + 2) >> 2);
				z = scaled_div(a12 + a21, u);
			end
			default: begin
				u = twice_root(one + a22 - a00 - a11);
				w = scaled_div(a10 - a01, u);
				x = scaled_div(a02 + a20, u);
				y = scaled_div(a12 + a21, u);
				z = sat_q((u + 2) >> 2);
			end
		endcase
		q.w = w[Q_W-1:0]; q.x = x[Q_W-1:0]; q.y = y[Q_W-1:0]; q.z = z[Q_W-1:0];
		q.tx = p.tx; q.ty = p.ty; q.tz = p.tz;
		return q;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results, what, got, want);
		errors++;
	endtask

	// acceptance monitor, result checker and watchdog share the sampling edge
	always @(posedge clk) begin
		quat_pose_t want;
		quat_pose_t typed;
		logic       has_typed;
		logic       progress;
		if (arst_n) begin
			progress = 1'b0;
			if (start && !busy) begin
				pending_quats.push_back(quat_of_pose({m00, m10, m20, m01, m11, m21,
					m02, m12, m22, trans_in_x, trans_in_y, trans_in_z}));
				accepted <= accepted + 1;
				progress = 1'b1;
			end
			if (done) begin
				progress = 1'b1;
				results <= results + 1;
				if (pending_quats.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					errors++;
				end else begin
					want = pending_quats.pop_front();
					has_typed = typed_known.pop_front();
					typed = typed_quats.pop_front();
					if (has_typed && typed != want) begin
						$display("model disagrees with typed row at result %0d", results);
						errors++;
					end
					if (quat_w != want.w) report_mismatch("quat_w", quat_w, want.w);
					if (quat_x != want.x) report_mismatch("quat_x", quat_x, want.x);
					if (quat_y != want.y) report_mismatch("quat_y", quat_y, want.y);
					if (quat_z != want.z) report_mismatch("quat_z", quat_z, want.z);
					if (trans_out_x != want.tx) report_mismatch("trans_out_x", trans_out_x, want.tx);
					if (trans_out_y != want.ty) report_mismatch("trans_out_y", trans_out_y, want.ty);
					if (trans_out_z != want.tz) report_mismatch("trans_out_z", trans_out_z, want.tz);
				end
			end
			idle_cycles <= progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("timeout: no progress in %0d cycles", WATCHDOG);
				$display("rotation_matrix_to_quaternion regression: fail");
				$finish;
			end
		end
	end

	task automatic send_pose(input pose_t p, input logic known, input quat_pose_t typed);
		int gap;
		start <= 1'b1;
		{m00, m10, m20, m01, m11, m21, m02, m12, m22} <=
			{p.m00, p.m10, p.m20, p.m01, p.m11, p.m21, p.m02, p.m12, p.m22};
		trans_in_x <= p.tx; trans_in_y <= p.ty; trans_in_z <= p.tz;
		typed_known.push_back(known);
		typed_quats.push_back(typed);
		branch_count[pick_branch(p)]++;
		do @(posedge clk); while (busy);
		// mostly back to back, some short gaps, a few long ones
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: gap = 0;
			5, 6, 7, 8: gap = $urandom_range(1, 4);
			default: gap = $urandom_range(10, 60);
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [M_W-1:0] near_rot_entry();
		case ($urandom_range(0, 3))
			0: return 16'(0);
			1: return ONE;
			2: return -ONE;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic pose_t random_pose();
		pose_t p;
		int kind;
		logic signed [M_W-1:0] d;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			16'($urandom)};
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			// entries of a plausible rotation, content random
			{p.m00, p.m10, p.m20, p.m01, p.m11, p.m21, p.m02, p.m12, p.m22} =
				{near_rot_entry(), near_rot_entry(), near_rot_entry(), near_rot_entry(),
				near_rot_entry(), near_rot_entry(), near_rot_entry(), near_rot_entry(),
				near_rot_entry()};
		end else if (kind < 7) begin
			// diagonal ties and small traces around the branch boundaries
			d = 16'($signed($urandom_range(0, 4000)) - 2000);
			p.m00 = d;
			p.m11 = ($urandom_range(0, 1)) ? d : 16'(d - $signed($urandom_range(0, 3)));
			p.m22 = ($urandom_range(0, 1)) ? d : 16'(-(p.m00 + p.m11)
				+ $signed($urandom_range(0, 2)));
		end
		return p;
	endfunction

	row_t rows[$];

	function automatic row_t mk_row(input logic signed [M_W-1:0] a00, a11, a22,
		input logic signed [M_W-1:0] off, input logic known,
		input logic signed [Q_W-1:0] w, x, y, z);
		row_t r;
		r.p = '{m00: a00, m10: off, m20: off, m01: off, m11: a11, m21: off,
			m02: off, m12: off, m22: a22, tx: 32'sh7fffffff, ty: 32'sh80000000, tz: 32'sd0};
		r.known = known;
		r.w = w; r.x = x; r.y = y; r.z = z;
		return r;
	endfunction

	initial begin
		row_t r;
		quat_pose_t typed;
		arst_n = 1'b0;
		start = 1'b0;
		{m00, m10, m20, m01, m11, m21, m02, m12, m22} = '0;
		{trans_in_x, trans_in_y, trans_in_z} = '0;
		errors = 0; accepted = 0; results = 0; idle_cycles = 0;
		branch_count = '{0, 0, 0, 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, half-turns about each axis, zero matrix
		rows.push_back(mk_row(ONE, ONE, ONE, 0, 1, ONE, 0, 0, 0));
		rows.push_back(mk_row(ONE, -ONE, -ONE, 0, 1, 0, ONE, 0, 0));
		rows.push_back(mk_row(-ONE, ONE, -ONE, 0, 1, 0, 0, ONE, 0));
		rows.push_back(mk_row(-ONE, -ONE, ONE, 0, 1, 0, 0, 0, ONE));
		rows.push_back(mk_row(0, 0, 0, 0, 1, 0, 0, 0, 16'sd8192));
		// ties on the diagonal pass to the later branch
		rows.push_back(mk_row(100, 100, -300, 5, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(-50, -50, -50, -7, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(MINV, MINV, MINV, MAXV, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(MAXV, MAXV, MAXV, MINV, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(MAXV, MINV, MINV, MAXV, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(MINV, MAXV, MINV, MINV, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(MINV, MINV, MAXV, MAXV, 0, 0, 0, 0, 0));
		// trace of one lsb: root near one, quotients saturate
		r = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0);
		r.p.m21 = MAXV; r.p.m12 = MINV; r.p.m20 = MAXV; r.p.m10 = MINV;
		rows.push_back(r);
		r = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
		r.p.m01 = MAXV; r.p.m10 = MAXV; r.p.m02 = MINV; r.p.m20 = MINV;
		r.p.m12 = MAXV; r.p.m21 = MAXV;
		rows.push_back(r);
		r = mk_row(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0);
		r.p.tx = 32'sh80000000; r.p.ty = 32'sh7fffffff; r.p.tz = -32'sd1;
		rows.push_back(r);

		foreach (rows[i]) begin
			typed = '{w: rows[i].w, x: rows[i].x, y: rows[i].y, z: rows[i].z,
				tx: rows[i].p.tx, ty: rows[i].p.ty, tz: rows[i].p.tz};
			send_pose(rows[i].p, rows[i].known, typed);
		end
		repeat (N_RANDOM) send_pose(random_pose(), 1'b0, '0);
		start <= 1'b0;

		while (pending_quats.size() != 0) @(posedge clk);
		repeat (LAT + 8) @(posedge clk);

		$display("%0d poses in, %0d quaternions checked, %0d mismatches", accepted, results,
			errors);
		$display("branches: trace %0d, m00 %0d, m11 %0d, m22 %0d",
			branch_count[BR_W], branch_count[BR_X], branch_count[BR_Y], branch_count[BR_Z]);
		if (errors == 0) begin
			$display("rotation_matrix_to_quaternion regression: pass");
		end else begin
			$display("rotation_matrix_to_quaternion regression: fail");
		end
		$finish;
	end
endmodule
